@@ rtl/memory_region_map_allocator_defines.svh @@
// assertion macros for the region map allocator
// used by the top level only, no other dependencies
`ifndef MEMORY_REGION_MAP_ALLOCATOR_DEFINES_SVH
`define MEMORY_REGION_MAP_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define MRMA_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MRMA_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/mrma_pkg.sv @@
// shared types, codes and helpers for the region map allocator
// no dependencies
package mrma_pkg;

  localparam int TableDepth = 32;
  localparam logic [2:0] KindAvailable  = 3'd0;
  localparam logic [2:0] KindBootReclaim = 3'd5;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_RESERVE = 2'd1,
    OP_ALLOC   = 2'd2,
    OP_READ    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_RANGE   = 2'd2,
    ST_NOSPACE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD  = 3'd0,
    CELL_LOAD  = 3'd1,
    CELL_SORT  = 3'd2,
    CELL_SHIFT = 3'd3,
    CELL_PREP  = 3'd4
  } cell_op_e;

  typedef struct packed {
    logic        valid;
    logic [63:0] start;
    logic [63:0] size;
    logic [2:0]  kind;
  } entry_t;

  typedef struct packed {
    cell_op_e    op;
    logic        parity;
    entry_t      load;
    entry_t      tail;
    logic [63:0] qaddr;
    logic [64:0] qend;
    logic [32:0] bytes;
  } cell_cmd_t;

  // holes move right, valid entries ordered by start, equal starts stay
  function automatic logic entry_swap(input entry_t l, input entry_t r);
    return (!l.valid && r.valid) || (l.valid && r.valid && (l.start > r.start));
  endfunction

endpackage

@@ rtl/mrma_cell.sv @@
// one table slot of the region chain: holds an entry, swaps or shifts with neighbors
// depends on mrma_pkg
module mrma_cell #(
  parameter int IDX  = 0,
  parameter bit LAST = 1'b0,
  parameter int IW   = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mrma_pkg::cell_cmd_t cmd_i,
  input  logic [IW-1:0]       load_idx_i,
  input  mrma_pkg::entry_t    left_i,
  input  mrma_pkg::entry_t    right_i,
  output mrma_pkg::entry_t    entry_o,
  output logic                hit_o,
  output logic                alloc_hit_o,
  output logic [63:0]         begin_o
);

  localparam logic Par = 1'(IDX % 2);

  mrma_pkg::entry_t ent_q, ent_d;
  logic             elig_q, elig_d;
  logic [51:0]      beg_q, beg_d;
  logic [64:0]      cend;
  logic [64:0]      aend;
  logic             left_role, right_role;
  mrma_pkg::entry_t rnb;

  assign rnb  = LAST ? cmd_i.tail : right_i;
  assign cend = {1'b0, ent_q.start} + {1'b0, ent_q.size};
  assign aend = {1'b0, beg_q, 12'b0} + {32'b0, cmd_i.bytes};

  assign left_role  = !LAST && (cmd_i.parity == Par);
  assign right_role = (IDX != 0) && (cmd_i.parity != Par);

  always_comb begin
    ent_d  = ent_q;
    elig_d = elig_q;
    beg_d  = beg_q;
    case (cmd_i.op)
      mrma_pkg::CELL_LOAD: begin
        if (load_idx_i == IW'(IDX)) ent_d = cmd_i.load;
      end
      mrma_pkg::CELL_SORT: begin
        if (left_role && mrma_pkg::entry_swap(ent_q, right_i)) ent_d = right_i;
        else if (right_role && mrma_pkg::entry_swap(left_i, ent_q)) ent_d = left_i;
      end
      mrma_pkg::CELL_SHIFT: ent_d = rnb;
      mrma_pkg::CELL_PREP: begin
        // start must round up to a page without passing the top of the space
        elig_d = ent_q.valid && (ent_q.kind == mrma_pkg::KindAvailable) &&
                 !((&ent_q.start[63:12]) && (|ent_q.start[11:0]));
        beg_d  = ent_q.start[63:12] + 52'(|ent_q.start[11:0]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else begin
      ent_q <= ent_d;
    end
  end

  always_ff @(posedge clk_i) begin
    elig_q <= elig_d;
    beg_q  <= beg_d;
  end

  assign entry_o     = ent_q;
  assign hit_o       = ent_q.valid && (ent_q.start <= cmd_i.qaddr) && (cmd_i.qend <= cend);
  assign alloc_hit_o = elig_q && (aend <= cend);
  assign begin_o     = {beg_q, 12'b0};

endmodule

@@ rtl/memory_region_map_allocator.sv @@
// top level of the region map allocator: sequencer, merge unit and the cell chain
// depends on mrma_pkg, mrma_cell and memory_region_map_allocator_defines.svh
//
// channel   direction  handshake
// command   in         start high, busy low
// result    out        result_valid_o, one cycle, no stall
//
// read, full-table add and zero-page allocate answer in the cycle after the command beat.
// a reserve steps through S_QEND and S_RES_SCAN and a miss answers from S_RES_SEL; one
// with nothing left over goes on through S_RES_LEN and S_RES_DEC and answers from S_APP.
// allocate first searches in S_ALC_PREP, S_ALC_SCAN and S_ALC_SEL. each appended piece
// costs a full odd-even sort of TableDepth+1 phases, a merge shift and a second sort pass.
// reset empties the table at once; the receiver cannot stall results.
`include "memory_region_map_allocator_defines.svh"

module memory_region_map_allocator #(
  parameter int TableDepth = mrma_pkg::TableDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation_i,
  input  logic [63:0] region_addr_i,
  input  logic [63:0] region_length_i,
  input  logic [2:0]  region_type_i,
  input  logic [20:0] page_count_i,
  input  logic [4:0]  entry_index_i,
  output logic        result_valid_o,
  output logic [1:0]  status_o,
  output logic [63:0] alloc_addr_o,
  output logic [63:0] entry_addr_o,
  output logic [63:0] entry_length_o,
  output logic [2:0]  entry_type_o,
  output logic [5:0]  entry_total_o
);

  localparam int NC  = TableDepth + 1;
  localparam int CIW = $clog2(NC);
  localparam int CW  = $clog2(TableDepth + 1);
  localparam int PW  = $clog2(NC);

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_QEND     = 13'b0000000000010,
    S_RES_SCAN = 13'b0000000000100,
    S_RES_SEL  = 13'b0000000001000,
    S_RES_LEN  = 13'b0000000010000,
    S_RES_DEC  = 13'b0000000100000,
    S_APP      = 13'b0000001000000,
    S_SORT     = 13'b0000010000000,
    S_MERGE    = 13'b0000100000000,
    S_COMPACT  = 13'b0001000000000,
    S_ALC_PREP = 13'b0010000000000,
    S_ALC_SCAN = 13'b0100000000000,
    S_ALC_SEL  = 13'b1000000000000
  } state_e;

  state_e              state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic [PW-1:0]       phase_q, phase_d;
  mrma_pkg::entry_t    acc_q, acc_d;
  logic [63:0]         qaddr_q, qaddr_d, qlen_q, qlen_d;
  logic [2:0]          qtype_q, qtype_d;
  logic [64:0]         qend_q, qend_d;
  logic [20:0]         pages_q, pages_d;
  logic                alloc_q, alloc_d;
  logic [NC-1:0]       hit_q, hit_d;
  logic [CIW-1:0]      sel_q, sel_d;
  logic [63:0]         os_q, os_d, ol_q, ol_d, len1_q, len1_d, oend_q, oend_d;
  logic [63:0]         len2_q, len2_d;
  logic [2:0]          ok_q, ok_d;
  logic                pend1_q, pend1_d, pend2_q, pend2_d;
  logic                rv_q, rv_d;
  logic [1:0]          status_q, status_d;
  logic [63:0]         aaddr_q, aaddr_d, eaddr_q, eaddr_d, elen_q, elen_d;
  logic [2:0]          etype_q, etype_d;
  logic [5:0]          total_q, total_d;

  mrma_pkg::cell_cmd_t cmd;
  logic [CIW-1:0]      load_idx;
  mrma_pkg::entry_t    ents [NC];
  logic [NC-1:0]       hits, ahits;
  logic [63:0]         begs [NC];
  logic                sel_found;
  logic [CIW-1:0]      sel_idx;
  logic [CIW-1:0]      rd_idx;
  mrma_pkg::entry_t    rd_ent;
  logic [64:0]         acc_end;
  logic                touch;
  logic [1:0]          need;
  logic [63:0]         len2;
  logic                accept;

  // cell chain
  for (genvar k = 0; k < NC; k++) begin : g_cell
    mrma_pkg::entry_t lnb, rnb;
    if (k == 0) begin : g_l0
      assign lnb = '0;
    end else begin : g_ln
      assign lnb = ents[k-1];
    end
    if (k == NC - 1) begin : g_rl
      assign rnb = cmd.tail;
    end else begin : g_rn
      assign rnb = ents[k+1];
    end
    mrma_cell #(
      .IDX  (k),
      .LAST (k == NC - 1),
      .IW   (CIW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .load_idx_i  (load_idx),
      .left_i      (lnb),
      .right_i     (rnb),
      .entry_o     (ents[k]),
      .hit_o       (hits[k]),
      .alloc_hit_o (ahits[k]),
      .begin_o     (begs[k])
    );
  end

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  // first set bit of the registered hit vector
  always_comb begin
    sel_found = 1'b0;
    sel_idx   = '0;
    for (int k = NC - 1; k >= 0; k--) begin
      if (hit_q[k]) begin
        sel_found = 1'b1;
        sel_idx   = CIW'(k);
      end
    end
  end

  assign rd_idx  = (state_q == S_IDLE) ? CIW'(entry_index_i) : sel_idx;
  assign rd_ent  = ents[rd_idx];
  assign acc_end = {1'b0, acc_q.start} + {1'b0, acc_q.size};
  assign touch   = !acc_end[64] && (acc_end[63:0] == ents[0].start);
  assign len2    = oend_q - qend_q[63:0];
  assign need    = {1'b0, (len1_q != 64'd0)} + {1'b0, (len2 != 64'd0)};

  always_comb begin
    state_d  = state_q;   count_d = count_q;   phase_d = phase_q;  acc_d = acc_q;
    qaddr_d  = qaddr_q;   qlen_d  = qlen_q;    qtype_d = qtype_q;  qend_d = qend_q;
    pages_d  = pages_q;   alloc_d = alloc_q;   hit_d   = hit_q;    sel_d = sel_q;
    os_d     = os_q;      ol_d    = ol_q;      ok_d    = ok_q;     len1_d = len1_q;
    oend_d   = oend_q;    len2_d  = len2_q;    pend1_d = pend1_q;  pend2_d = pend2_q;
    rv_d     = 1'b0;      status_d = status_q; aaddr_d = aaddr_q;  eaddr_d = eaddr_q;
    elen_d   = elen_q;    etype_d = etype_q;   total_d = total_q;

    cmd        = '0;
    cmd.op     = mrma_pkg::CELL_HOLD;
    cmd.qaddr  = qaddr_q;
    cmd.qend   = qend_q;
    cmd.bytes  = {pages_q, 12'b0};
    cmd.parity = phase_q[0];
    load_idx   = CIW'(TableDepth);

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          qaddr_d = region_addr_i;
          qlen_d  = region_length_i;
          qtype_d = region_type_i;
          pages_d = page_count_i;
          alloc_d = 1'b0;
          pend1_d = 1'b0;
          pend2_d = 1'b0;
          aaddr_d = '0; eaddr_d = '0; elen_d = '0; etype_d = '0;
          total_d = 6'(count_q);
          case (operation_i)
            mrma_pkg::OP_ADD: begin
              if (32'(count_q) >= TableDepth) begin
                rv_d = 1'b1; status_d = mrma_pkg::ST_FULL;
              end else begin
                cmd.op   = mrma_pkg::CELL_LOAD;
                cmd.load = '{valid: 1'b1, start: region_addr_i,
                             size: region_length_i, kind: region_type_i};
                phase_d  = '0;
                state_d  = S_SORT;
              end
            end
            mrma_pkg::OP_RESERVE: state_d = S_QEND;
            mrma_pkg::OP_ALLOC: begin
              if (page_count_i == 21'd0) begin
                rv_d = 1'b1; status_d = mrma_pkg::ST_NOSPACE;
              end else begin
                state_d = S_ALC_PREP;
              end
            end
            default: begin
              rv_d = 1'b1;
              if (32'(entry_index_i) < 32'(count_q)) begin
                status_d = mrma_pkg::ST_OK;
                eaddr_d  = rd_ent.start;
                elen_d   = rd_ent.size;
                etype_d  = rd_ent.kind;
              end else begin
                status_d = mrma_pkg::ST_RANGE;
              end
            end
          endcase
        end
      end
      S_QEND: begin
        qend_d  = {1'b0, qaddr_q} + {1'b0, qlen_q};
        state_d = S_RES_SCAN;
      end
      S_RES_SCAN: begin
        hit_d   = hits;
        state_d = S_RES_SEL;
      end
      S_RES_SEL: begin
        if (!sel_found) begin
          rv_d = 1'b1; status_d = mrma_pkg::ST_RANGE; total_d = 6'(count_q);
          state_d = S_IDLE;
        end else begin
          sel_d = sel_idx;
          os_d  = rd_ent.start;
          ol_d  = rd_ent.size;
          ok_d  = rd_ent.kind;
          state_d = S_RES_LEN;
        end
      end
      S_RES_LEN: begin
        len1_d  = qaddr_q - os_q;
        oend_d  = os_q + ol_q;
        state_d = S_RES_DEC;
      end
      S_RES_DEC: begin
        if (32'(count_q) + 32'(need) > TableDepth) begin
          rv_d = 1'b1; status_d = mrma_pkg::ST_FULL; aaddr_d = '0;
          total_d = 6'(count_q);
          state_d = S_IDLE;
        end else begin
          cmd.op   = mrma_pkg::CELL_LOAD;
          load_idx = sel_q;
          cmd.load = '{valid: 1'b1, start: qaddr_q, size: qlen_q, kind: qtype_q};
          len2_d   = len2;
          pend1_d  = (len1_q != 64'd0);
          pend2_d  = (len2 != 64'd0);
          state_d  = S_APP;
        end
      end
      S_APP: begin
        phase_d = '0;
        if (pend1_q) begin
          cmd.op   = mrma_pkg::CELL_LOAD;
          cmd.load = '{valid: 1'b1, start: os_q, size: len1_q, kind: ok_q};
          pend1_d  = 1'b0;
          state_d  = S_SORT;
        end else if (pend2_q) begin
          cmd.op   = mrma_pkg::CELL_LOAD;
          cmd.load = '{valid: 1'b1, start: qend_q[63:0], size: len2_q, kind: ok_q};
          pend2_d  = 1'b0;
          state_d  = S_SORT;
        end else begin
          rv_d     = 1'b1;
          status_d = mrma_pkg::ST_OK;
          aaddr_d  = alloc_q ? qaddr_q : 64'd0;
          total_d  = 6'(count_q);
          state_d  = S_IDLE;
        end
      end
      S_SORT: begin
        cmd.op  = mrma_pkg::CELL_SORT;
        phase_d = phase_q + PW'(1);
        if (phase_q == PW'(NC - 1)) begin
          acc_d.valid = 1'b0;
          count_d     = '0;
          state_d     = S_MERGE;
        end
      end
      S_MERGE: begin
        // pop the head, fold it into the accumulator or push the accumulator to the tail
        cmd.op = mrma_pkg::CELL_SHIFT;
        if (ents[0].valid && acc_q.valid && (acc_q.kind == ents[0].kind) && touch) begin
          cmd.tail.valid = 1'b0;
          acc_d.size     = acc_q.size + ents[0].size;
        end else begin
          cmd.tail = acc_q;
          count_d  = count_q + CW'(acc_q.valid);
          acc_d    = ents[0];
          if (!ents[0].valid) begin
            phase_d = '0;
            state_d = S_COMPACT;
          end
        end
      end
      S_COMPACT: begin
        cmd.op  = mrma_pkg::CELL_SORT;
        phase_d = phase_q + PW'(1);
        if (phase_q == PW'(NC - 1)) state_d = S_APP;
      end
      S_ALC_PREP: begin
        cmd.op  = mrma_pkg::CELL_PREP;
        state_d = S_ALC_SCAN;
      end
      S_ALC_SCAN: begin
        hit_d   = ahits;
        state_d = S_ALC_SEL;
      end
      S_ALC_SEL: begin
        if (!sel_found) begin
          rv_d = 1'b1; status_d = mrma_pkg::ST_NOSPACE; total_d = 6'(count_q);
          state_d = S_IDLE;
        end else begin
          qaddr_d = begs[sel_idx];
          qlen_d  = 64'({pages_q, 12'b0});
          qtype_d = mrma_pkg::KindBootReclaim;
          alloc_d = 1'b1;
          state_d = S_QEND;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      phase_q     <= '0;
      acc_q       <= '0;
      alloc_q     <= 1'b0;
      pend1_q     <= 1'b0;
      pend2_q     <= 1'b0;
      rv_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      phase_q     <= phase_d;
      acc_q       <= acc_d;
      alloc_q     <= alloc_d;
      pend1_q     <= pend1_d;
      pend2_q     <= pend2_d;
      rv_q        <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qaddr_q  <= qaddr_d;  qlen_q  <= qlen_d;  qtype_q <= qtype_d;  qend_q <= qend_d;
    pages_q  <= pages_d;  hit_q   <= hit_d;   sel_q   <= sel_d;
    os_q     <= os_d;     ol_q    <= ol_d;    ok_q    <= ok_d;
    len1_q   <= len1_d;   oend_q  <= oend_d;  len2_q  <= len2_d;
    status_q <= status_d; aaddr_q <= aaddr_d; eaddr_q <= eaddr_d;
    elen_q   <= elen_d;   etype_q <= etype_d; total_q <= total_d;
  end

  assign result_valid_o = rv_q;
  assign status_o       = status_q;
  assign alloc_addr_o   = aaddr_q;
  assign entry_addr_o   = eaddr_q;
  assign entry_length_o = elen_q;
  assign entry_type_o   = etype_q;
  assign entry_total_o  = total_q;

  `MRMA_ASSERT_IMP(a_count_bound, clk_i, rst_ni, 1'b1, 32'(count_q) <= TableDepth, "count overflow")
  `MRMA_ASSERT_IMP(a_spare_free, clk_i, rst_ni, state_q == S_IDLE, !ents[NC-1].valid, "spare busy")
  `MRMA_ASSERT_IMP(a_head_empty, clk_i, rst_ni, !busy && !ents[0].valid, count_q == '0, "empty head")
  `MRMA_ASSERT_NXT(a_no_stray_beat, clk_i, rst_ni, !busy && !start, !result_valid_o, "stray beat")

endmodule
